[rtl/h264_sps_resolution_parser_assert.svh]
// Assertion macros for the SPS resolution parser.
`ifndef H264_SPS_RESOLUTION_PARSER_ASSERT_SVH
`define H264_SPS_RESOLUTION_PARSER_ASSERT_SVH
// Implication check, disabled during reset.
`define SPS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Next-cycle implication check, disabled during reset.
`define SPS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

[rtl/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants of the SPS resolution parser.
// ----------------------------------------------------------------------------
package sps_pkg;

	typedef enum logic [5:0] {
		P_PROFILE, P_CONSTR, P_LEVEL, P_SPS_ID, P_CHROMA, P_SEP_PLANE,
		P_DEPTH_LUMA, P_DEPTH_CHROMA, P_BYPASS, P_MATRIX, P_LIST_FLAG, P_DELTA,
		P_LOG2_FRAME, P_POC_TYPE, P_POC_LSB, P_DELTA_ZERO, P_OFF_NONREF,
		P_OFF_TB, P_CYCLE_N, P_CYCLE_OFF, P_NUM_REF, P_GAPS, P_WIDTH, P_HEIGHT,
		P_FMO, P_MBAFF, P_DIRECT, P_CROP_FLAG, P_CROP_L, P_CROP_R, P_CROP_T,
		P_CROP_B, P_DONE, P_FAIL
	} pos_t;

	localparam int BYTE_BITS = 8;
	localparam int QUEUE_DEPTH = 2;

	// Queue entry between front and back.
	typedef struct packed {
		logic [BYTE_BITS-1:0] data;
		logic                 last;
	} beat_t;

	function automatic logic [5:0] fixed_bits(input pos_t p);
		case (p)
			P_PROFILE, P_CONSTR, P_LEVEL: fixed_bits = 6'd8;
			P_SEP_PLANE, P_BYPASS, P_MATRIX, P_LIST_FLAG, P_DELTA_ZERO, P_GAPS,
			P_FMO, P_MBAFF, P_DIRECT, P_CROP_FLAG: fixed_bits = 6'd1;
			default: fixed_bits = 6'd0;
		endcase
	endfunction

	function automatic logic high_profile(input logic [7:0] p);
		high_profile = (p == 8'd100) || (p == 8'd110) || (p == 8'd122) ||
			(p == 8'd244) || (p == 8'd44) || (p == 8'd83) || (p == 8'd86) ||
			(p == 8'd118) || (p == 8'd128);
	endfunction

endpackage

[rtl/sps_front.sv]
// ----------------------------------------------------------------------------
// sps_front
// Input side: accepts byte beats into a short queue for the bit parser.
// ----------------------------------------------------------------------------
module sps_front import sps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 stall,
	input  logic [BYTE_BITS-1:0] data_byte,
	input  logic                 last_byte,
	output logic                 q_valid,
	output beat_t                q_head,
	input  logic                 q_pop
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	beat_t          mem_q [QUEUE_DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [AW:0]    cnt_q;
	logic           push;

	assign stall   = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign push    = valid && !stall;
	assign q_valid = (cnt_q != '0);
	assign q_head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{data: data_byte, last: last_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end

endmodule

[rtl/sps_back.sv]
// ----------------------------------------------------------------------------
// sps_back
// Bit-serial SPS syntax walker and result computation with output register.
// ----------------------------------------------------------------------------
module sps_back import sps_pkg::*; #(
	parameter int MAX_CODE_BITS  = 32,
	parameter int DIMENSION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  beat_t       q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] coded_width,
	output logic [15:0] coded_height,
	output logic [15:0] display_width,
	output logic [15:0] display_height,
	output logic        size_changed,
	output logic        stream_error
);

	`include "h264_sps_resolution_parser_assert.svh"

	localparam int ZW = $clog2(MAX_CODE_BITS + 1);
	localparam logic [16:0] DIM_MAX = 17'((64'd1 << DIMENSION_BITS) - 1);

	// bit walker
	logic                 busy_q;
	logic [2:0]           bit_q;
	logic [BYTE_BITS-1:0] sh_q;
	logic                 last_q;
	pos_t                 pos_q;
	logic [MAX_CODE_BITS-1:0] acc_q;
	logic [ZW-1:0]        lz_q;
	logic [ZW-1:0]        left_q;
	logic [7:0]           prof_q;
	logic [2:0]           chroma_q;
	logic                 fmo_q;
	logic [15:0]          dim_q [2];
	logic [15:0]          crop_q [4];
	logic [7:0]           loop_q;
	logic [3:0]           list_q;
	logic [7:0]           slast_q;

	// finish pipeline
	logic        fin_s1, err_s1;
	logic [16:0] cw_s1, ch_s1;
	logic [17:0] cx_s1, cy_s1;
	logic        out_full_q;

	logic b;
	assign b = sh_q[BYTE_BITS-1];

	logic        load;
	logic        bit_done;
	logic        can_finish;
	// the output register must be free (or draining) when the result lands
	assign can_finish = !fin_s1 && !(out_full_q && out_stall);
	assign bit_done = busy_q && (bit_q == 3'd7) && (!last_q || can_finish);
	assign load     = q_valid && (!busy_q || bit_done);
	assign q_pop    = load;

	// value of completed field
	logic        fixed;
	logic [MAX_CODE_BITS:0] eg_val;
	assign fixed = fixed_bits(pos_q) != 6'd0;
	logic [MAX_CODE_BITS-1:0] acc_nx;
	assign acc_nx = {acc_q[MAX_CODE_BITS-2:0], b};

	logic      complete;
	logic [MAX_CODE_BITS:0] val;
	logic [MAX_CODE_BITS:0] ones;
	assign ones = ((MAX_CODE_BITS+1)'(1) << lz_q) - 1'b1;

	always_comb begin
		complete = 1'b0;
		val = '0;
		eg_val = ones + (MAX_CODE_BITS+1)'(acc_nx);
		if (pos_q < P_DONE) begin
			if (fixed) begin
				complete = (left_q == ZW'(1));
				val = (MAX_CODE_BITS+1)'(acc_nx);
			end else if (left_q == '0) begin
				complete = b && (lz_q == '0);
				val = '0;
			end else begin
				complete = (left_q == ZW'(1));
				val = eg_val;
			end
		end
	end

	function automatic logic [15:0] sat16(input logic [MAX_CODE_BITS:0] v);
		sat16 = (v > (MAX_CODE_BITS+1)'(65535)) ? 16'hFFFF : v[15:0];
	endfunction

	// scaling delta
	logic [7:0] delta, nxt8;
	logic [7:0] lsize;
	assign delta = val[0] ? 8'(val[8:1] + 8'd1) : 8'(8'd0 - val[8:1]);
	assign nxt8  = slast_q + delta;
	assign lsize = (list_q < 4'd6) ? 8'd16 : 8'd64;

	pos_t np;
	logic go;
	logic next_list;
	always_comb begin
		np = P_FAIL;
		go = 1'b1;
		next_list = 1'b0;
		case (pos_q)
			P_PROFILE:      np = P_CONSTR;
			P_CONSTR:       np = P_LEVEL;
			P_LEVEL:        np = P_SPS_ID;
			P_SPS_ID:       np = high_profile(prof_q) ? P_CHROMA : P_LOG2_FRAME;
			P_CHROMA:       np = (val == 3) ? P_SEP_PLANE : P_DEPTH_LUMA;
			P_SEP_PLANE:    np = P_DEPTH_LUMA;
			P_DEPTH_LUMA:   np = P_DEPTH_CHROMA;
			P_DEPTH_CHROMA: np = P_BYPASS;
			P_BYPASS:       np = P_MATRIX;
			P_MATRIX:       np = val[0] ? P_LIST_FLAG : P_LOG2_FRAME;
			P_LIST_FLAG: begin
				np = P_DELTA;
				next_list = !val[0];
			end
			P_DELTA: begin
				np = P_DELTA;
				next_list = (nxt8 == 8'd0) || (8'(loop_q + 8'd1) >= lsize);
			end
			P_LOG2_FRAME:   np = P_POC_TYPE;
			P_POC_TYPE:     np = (val == 0) ? P_POC_LSB :
				((val == 1) ? P_DELTA_ZERO : P_NUM_REF);
			P_POC_LSB:      np = P_NUM_REF;
			P_DELTA_ZERO:   np = P_OFF_NONREF;
			P_OFF_NONREF:   np = P_OFF_TB;
			P_OFF_TB:       np = P_CYCLE_N;
			P_CYCLE_N:      np = (val != 0) ? P_CYCLE_OFF : P_NUM_REF;
			P_CYCLE_OFF:    np = (loop_q > 8'd1) ? P_CYCLE_OFF : P_NUM_REF;
			P_NUM_REF:      np = P_GAPS;
			P_GAPS:         np = P_WIDTH;
			P_WIDTH:        np = P_HEIGHT;
			P_HEIGHT:       np = P_FMO;
			P_FMO:          np = val[0] ? P_DIRECT : P_MBAFF;
			P_MBAFF:        np = P_DIRECT;
			P_DIRECT:       np = P_CROP_FLAG;
			P_CROP_FLAG:    np = val[0] ? P_CROP_L : P_DONE;
			P_CROP_L:       np = P_CROP_R;
			P_CROP_R:       np = P_CROP_T;
			P_CROP_T:       np = P_CROP_B;
			P_CROP_B:       np = P_DONE;
			default:        go = 1'b0;
		endcase
		if (next_list) begin
			np = ((list_q + 4'd1) < ((chroma_q == 3'd3) ? 4'd12 : 4'd8)) ?
				P_LIST_FLAG : P_LOG2_FRAME;
		end
	end

	logic last_bit;
	assign last_bit = bit_done && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q  <= '0;
			pos_q  <= P_PROFILE;
			left_q <= ZW'(8);
			lz_q   <= '0;
			acc_q  <= '0;
			prof_q <= '0;
			chroma_q <= 3'd1;
			fmo_q  <= 1'b0;
			dim_q  <= '{default: '0};
			crop_q <= '{default: '0};
			loop_q <= '0;
			list_q <= '0;
			slast_q <= 8'd8;
			sh_q   <= '0;
			last_q <= 1'b0;
		end else begin
			if (busy_q && !(bit_q == 3'd7 && last_q && !can_finish)) begin
				sh_q  <= {sh_q[BYTE_BITS-2:0], 1'b0};
				bit_q <= bit_q + 3'd1;
				if (bit_q == 3'd7) busy_q <= 1'b0;
				if (pos_q < P_DONE) begin
					if (fixed || left_q != '0) begin
						acc_q  <= acc_nx;
						left_q <= left_q - 1'b1;
					end else if (!b) begin
						lz_q <= lz_q + 1'b1;
						if (lz_q + 1'b1 >= ZW'(MAX_CODE_BITS)) begin
							pos_q <= P_FAIL;
							acc_q <= '0;
							lz_q <= '0;
						end
					end else if (lz_q != '0) begin
						left_q <= lz_q;
						acc_q <= '0;
					end
					if (complete && go) begin
						pos_q  <= np;
						acc_q  <= '0;
						lz_q   <= '0;
						left_q <= ZW'(fixed_bits(np));
						case (pos_q)
							P_PROFILE: prof_q <= val[7:0];
							P_CHROMA: chroma_q <= (val > 7) ? 3'd7 : val[2:0];
							P_MATRIX: list_q <= '0;
							P_LIST_FLAG: begin
								if (val[0]) begin
									slast_q <= 8'd8;
									loop_q  <= '0;
								end
							end
							P_DELTA: begin
								if (nxt8 != 8'd0) slast_q <= nxt8;
								loop_q <= loop_q + 8'd1;
							end
							P_CYCLE_N: loop_q <= (val > 255) ? 8'd255 : val[7:0];
							P_CYCLE_OFF: if (loop_q != 0) loop_q <= loop_q - 8'd1;
							P_WIDTH: dim_q[0] <= sat16(val);
							P_HEIGHT: dim_q[1] <= sat16(val);
							P_FMO: fmo_q <= val[0];
							P_CROP_L: crop_q[0] <= sat16(val);
							P_CROP_R: crop_q[1] <= sat16(val);
							P_CROP_T: crop_q[2] <= sat16(val);
							P_CROP_B: crop_q[3] <= sat16(val);
							default: ;
						endcase
						if (next_list) list_q <= list_q + 4'd1;
					end
				end
			end
			if (last_bit) begin
				pos_q  <= P_PROFILE;
				left_q <= ZW'(8);
				lz_q   <= '0;
				acc_q  <= '0;
				prof_q <= '0;
				chroma_q <= 3'd1;
				fmo_q  <= 1'b0;
				dim_q  <= '{default: '0};
				crop_q <= '{default: '0};
				loop_q <= '0;
				list_q <= '0;
				slast_q <= 8'd8;
			end
			if (load) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
				sh_q   <= q_head.data;
				last_q <= q_head.last;
			end
		end
	end

	// final position after the last bit
	pos_t fpos;
	always_comb begin
		fpos = pos_q;
		if (pos_q < P_DONE && complete && go) fpos = np;
		else if (pos_q < P_DONE && !fixed && left_q == '0 && !b &&
			(lz_q + 1'b1 >= ZW'(MAX_CODE_BITS))) fpos = P_FAIL;
	end

	logic [15:0] fcrop [4];
	logic        ffmo;
	logic [15:0] fdim1;
	always_comb begin
		fcrop = crop_q;
		ffmo = fmo_q;
		fdim1 = dim_q[1];
		if (pos_q == P_CROP_B && complete) fcrop[3] = sat16(val);
	end

	// stage 1: coded size and crop amounts
	logic [16:0] cw_raw;
	logic [18:0] ch_raw;
	logic [1:0]  ux, uy;
	logic [16:0] sx, sy;
	assign cw_raw = 17'(DIM_MAX) < ({1'b0, dim_q[0]} + 17'd1) ? 17'h1FFFF :
		{1'b0, dim_q[0]} + 17'd1;
	always_comb begin
		ux = 2'd1;
		uy = ffmo ? 2'd1 : 2'd2;
		case (chroma_q)
			3'd1: begin ux = 2'd2; uy = ffmo ? 2'd2 : 2'd3; end
			3'd2: ux = 2'd2;
			default: ;
		endcase
		sx = {1'b0, fcrop[0]} + {1'b0, fcrop[1]};
		sy = {1'b0, fcrop[2]} + {1'b0, fcrop[3]};
		ch_raw = 19'({2'b0, fdim1} + 19'd1) << (ffmo ? 1'b0 : 1'b1);
	end

	logic [21:0] cwm, chm;
	assign cwm = 22'({1'b0, dim_q[0]} + 17'd1) << 4;
	assign chm = 22'(ch_raw) << 4;

	logic [18:0] cxr, cyr;
	always_comb begin
		cxr = (ux == 2'd2) ? 19'({sx, 1'b0}) : 19'(sx);
		case (uy)
			2'd1: cyr = 19'(sy);
			2'd2: cyr = 19'({sy, 1'b0});
			default: cyr = 19'({sy, 2'b0});
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s1 <= 1'b0;
		end else begin
			fin_s1 <= last_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (last_bit) begin
			err_s1 <= (fpos != P_DONE);
			cw_s1  <= (cwm > 22'(DIM_MAX)) ? DIM_MAX : cwm[16:0];
			ch_s1  <= (chm > 22'(DIM_MAX)) ? DIM_MAX : chm[16:0];
			cx_s1  <= cxr[17:0] | {18{cxr[18]}};
			cy_s1  <= cyr[17:0] | {18{cyr[18]}};
		end
	end

	// stage 2: display size, change flag, output register
	logic [15:0] pw_q, ph_q;
	logic        chg;
	logic [15:0] cw16, ch16;
	assign cw16 = cw_s1[15:0];
	assign ch16 = ch_s1[15:0];
	assign chg = (pw_q == '0 && ph_q == '0) ||
		(pw_q != '0 && ph_q != '0 && (pw_q != cw16 || ph_q != ch16));
	assign out_valid = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
			pw_q <= '0;
			ph_q <= '0;
		end else begin
			if (out_full_q && !out_stall) out_full_q <= 1'b0;
			if (fin_s1) begin
				out_full_q <= 1'b1;
				if (!err_s1) begin
					pw_q <= cw16;
					ph_q <= ch16;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_s1) begin
			stream_error   <= err_s1;
			coded_width    <= err_s1 ? '0 : cw16;
			coded_height   <= err_s1 ? '0 : ch16;
			display_width  <= (err_s1 || {1'b0, cx_s1} >= {2'b0, cw_s1}) ? '0 :
				16'(cw_s1 - cx_s1[16:0]);
			display_height <= (err_s1 || {1'b0, cy_s1} >= {2'b0, ch_s1}) ? '0 :
				16'(ch_s1 - cy_s1[16:0]);
			size_changed   <= err_s1 ? 1'b0 : chg;
		end
	end

	logic unused;
	assign unused = ^{cw_raw, fdim1, ch_raw[18:17]};

	`SPS_ASSERT_IMP(a_no_overwrite, clk, arst_n, fin_s1, !(out_full_q && out_stall))
	`SPS_ASSERT_NXT(a_fin_shows, clk, arst_n, fin_s1, out_full_q)
	`SPS_ASSERT_IMP(a_err_zero, clk, arst_n, out_full_q && stream_error,
		coded_width == '0 && size_changed == 1'b0)

endmodule

[rtl/h264_sps_resolution_parser.sv]
// ----------------------------------------------------------------------------
// h264_sps_resolution_parser
// H.264 SPS coded and display size extraction, one payload byte per beat.
// ----------------------------------------------------------------------------
// Input channel: valid/stall with data_byte and last_byte, one payload byte
// per beat, MSB first. A two-entry queue takes beats while the parser works.
// The parser walks one bit per cycle except while it waits before the last
// bit of a final byte; that serial bit walker sets the sustained beat rate.
// Output channel: out_valid/out_stall, one result per beat marked last.
// When the last bit of the final byte is parsed, the result is registered
// in the stage 1 registers and then in the output register, where it is
// held. While the receiver stalls, the result holds; the parser finishes
// the next payload's bytes but waits before the last bit of a further final
// byte until the output register frees up.
// Reset clears the queue, the parse state and the remembered coded size.
// ----------------------------------------------------------------------------
module h264_sps_resolution_parser import sps_pkg::*; #(
	parameter int MAX_CODE_BITS  = 32,
	parameter int DIMENSION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] coded_width,
	output logic [15:0] coded_height,
	output logic [15:0] display_width,
	output logic [15:0] display_height,
	output logic        size_changed,
	output logic        stream_error
);

	logic  q_valid, q_pop;
	beat_t q_head;

	sps_front u_front (
		.clk, .arst_n, .valid, .stall, .data_byte, .last_byte,
		.q_valid, .q_head, .q_pop
	);

	sps_back #(
		.MAX_CODE_BITS(MAX_CODE_BITS),
		.DIMENSION_BITS(DIMENSION_BITS)
	) u_back (
		.clk, .arst_n, .q_valid, .q_head, .q_pop,
		.out_valid, .out_stall, .coded_width, .coded_height,
		.display_width, .display_height, .size_changed, .stream_error
	);

endmodule

[tb/h264_sps_resolution_parser_test.sv]
// ----------------------------------------------------------------------------
// h264_sps_resolution_parser_test
// Feeds SPS payload bytes (directed table, then random well-formed and broken
// parameter sets) under random idling on both sides; a bit-serial predictor
// models the syntax walk and each result beat is checked field by field.
// ----------------------------------------------------------------------------
module h264_sps_resolution_parser_test import sps_pkg::*; ();

	typedef struct packed {
		logic [15:0] cw, ch, dw, dh;
		logic        chg, err;
	} size_res_t;

	logic        clk, arst_n;
	logic        valid, stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid, out_stall;
	logic [15:0] coded_width, coded_height, display_width, display_height;
	logic        size_changed, stream_error;

	h264_sps_resolution_parser u_top (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.coded_width(coded_width), .coded_height(coded_height),
		.display_width(display_width), .display_height(display_height),
		.size_changed(size_changed), .stream_error(stream_error)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// predictor state
	int unsigned prv_w, prv_h, pos, acc, lzc, left, prof, chroma, fonly;
	int unsigned dims[2], crops[4], lcnt, lidx, slast;
	size_res_t   sizes_q[$];
	int          errors, cycles;
	int          snd_idle, rcv_idle;
	bit          hold_rcv;

	function automatic int unsigned fbits(int unsigned p);
		return (p < P_DONE) ? fixed_bits(pos_t'(p)) : 0;
	endfunction

	function automatic bit is_high(int unsigned p);
		return p == 100 || p == 110 || p == 122 || p == 244 || p == 44 ||
			p == 83 || p == 86 || p == 118 || p == 128;
	endfunction

	function automatic int unsigned sat(longint unsigned v);
		return v > 65535 ? 65535 : int'(v);
	endfunction

	function automatic void go(int unsigned p);
		pos = p; acc = 0; lzc = 0; left = fbits(p);
	endfunction

	function automatic void parse_clear();
		prof = 0; chroma = 1; fonly = 0; dims = '{0, 0}; crops = '{0, 0, 0, 0};
		lcnt = 0; lidx = 0; slast = 8;
		go(P_PROFILE);
	endfunction

	function automatic void next_list();
		lidx++;
		go(lidx < ((chroma == 3) ? 12 : 8) ? P_LIST_FLAG : P_LOG2_FRAME);
	endfunction

	function automatic void field_done(longint unsigned v);
		int unsigned dl, nx;
		case (pos)
			P_PROFILE: begin prof = v & 8'hff; go(P_CONSTR); end
			P_CONSTR: go(P_LEVEL);
			P_LEVEL: go(P_SPS_ID);
			P_SPS_ID: go(is_high(prof) ? P_CHROMA : P_LOG2_FRAME);
			P_CHROMA: begin
				chroma = v > 7 ? 7 : int'(v);
				go(v == 3 ? P_SEP_PLANE : P_DEPTH_LUMA);
			end
			P_SEP_PLANE: go(P_DEPTH_LUMA);
			P_DEPTH_LUMA: go(P_DEPTH_CHROMA);
			P_DEPTH_CHROMA: go(P_BYPASS);
			P_BYPASS: go(P_MATRIX);
			P_MATRIX: begin lidx = 0; go(v ? P_LIST_FLAG : P_LOG2_FRAME); end
			P_LIST_FLAG: begin
				if (v) begin slast = 8; lcnt = 0; go(P_DELTA); end
				else next_list();
			end
			P_DELTA: begin
				dl = v[0] ? int'((v + 1) >> 1) : (0 - int'(v >> 1));
				nx = (slast + dl) & 8'hff;
				if (nx != 0) slast = nx;
				lcnt++;
				if (nx == 0 || lcnt >= ((lidx < 6) ? 16 : 64)) next_list();
				else go(P_DELTA);
			end
			P_LOG2_FRAME: go(P_POC_TYPE);
			P_POC_TYPE: go(v == 0 ? P_POC_LSB : (v == 1 ? P_DELTA_ZERO : P_NUM_REF));
			P_POC_LSB: go(P_NUM_REF);
			P_DELTA_ZERO: go(P_OFF_NONREF);
			P_OFF_NONREF: go(P_OFF_TB);
			P_OFF_TB: go(P_CYCLE_N);
			P_CYCLE_N: begin
				lcnt = v > 255 ? 255 : int'(v);
				go(lcnt ? P_CYCLE_OFF : P_NUM_REF);
			end
			P_CYCLE_OFF: begin
				if (lcnt > 0) lcnt--;
				go(lcnt ? P_CYCLE_OFF : P_NUM_REF);
			end
			P_NUM_REF: go(P_GAPS);
			P_GAPS: go(P_WIDTH);
			P_WIDTH: begin dims[0] = sat(v); go(P_HEIGHT); end
			P_HEIGHT: begin dims[1] = sat(v); go(P_FMO); end
			P_FMO: begin fonly = v & 1; go(fonly ? P_DIRECT : P_MBAFF); end
			P_MBAFF: go(P_DIRECT);
			P_DIRECT: go(P_CROP_FLAG);
			P_CROP_FLAG: go(v ? P_CROP_L : P_DONE);
			P_CROP_L: begin crops[0] = sat(v); go(P_CROP_R); end
			P_CROP_R: begin crops[1] = sat(v); go(P_CROP_T); end
			P_CROP_T: begin crops[2] = sat(v); go(P_CROP_B); end
			P_CROP_B: begin crops[3] = sat(v); go(P_DONE); end
			default: go(P_FAIL);
		endcase
	endfunction

	function automatic void walk_bit(bit b);
		if (pos >= P_DONE) return;
		if (fbits(pos) != 0) begin
			acc = (acc << 1) | b; left--;
			if (left == 0) field_done(acc);
		end else if (left == 0) begin
			if (!b) begin
				lzc++;
				if (lzc >= 32) go(P_FAIL);
			end else if (lzc == 0) field_done(0);
			else begin left = lzc; acc = 0; end
		end else begin
			acc = (acc << 1) | b; left--;
			if (left == 0) field_done(((64'd1 << lzc) - 1) + acc);
		end
	endfunction

	// returns 1 and the result when the byte closes a parameter set
	function automatic bit predict_size(logic [7:0] d, logic l, output size_res_t r);
		longint unsigned cw, ch, fm, ux, uy, cx, cy;
		for (int i = 7; i >= 0; i--) walk_bit(d[i]);
		r = '{default: '0};
		if (!l) return 0;
		if (pos != P_DONE) r.err = 1'b1;
		else begin
			fm = 2 - fonly;
			cw = (longint'(dims[0]) + 1) * 16;
			ch = (longint'(dims[1]) + 1) * 16 * fm;
			if (cw > 65535) cw = 65535;
			if (ch > 65535) ch = 65535;
			r.chg = (prv_w == 0 && prv_h == 0) ||
				(prv_w != 0 && prv_h != 0 && (prv_w != cw || prv_h != ch));
			prv_w = 32'(cw); prv_h = 32'(ch);
			case (chroma)
				0: begin ux = 1; uy = fm; end
				1: begin ux = 2; uy = 2 * fm; end
				2: begin ux = 2; uy = fm; end
				default: begin ux = 1; uy = fm; end
			endcase
			cx = ux * (longint'(crops[0]) + crops[1]);
			cy = uy * (longint'(crops[2]) + crops[3]);
			r.cw = 16'(cw); r.ch = 16'(ch);
			r.dw = cx >= cw ? 16'd0 : 16'(cw - cx);
			r.dh = cy >= ch ? 16'd0 : 16'(ch - cy);
		end
		parse_clear();
		return 1;
	endfunction

	// ---- bit writer for building payloads
	bit bits_q[$];
	task automatic put(longint unsigned v, int n);
		for (int i = n - 1; i >= 0; i--) bits_q.push_back(v[i]);
	endtask
	task automatic put_ue(longint unsigned v);
		longint unsigned c = v + 1;
		int n = 0;
		while ((c >> (n + 1)) != 0) n++;
		put(0, n); put(c, n + 1);
	endtask
	task automatic put_se(int v);
		put_ue(v > 0 ? 2 * v - 1 : -2 * v);
	endtask
	function automatic longint unsigned rnd_ue();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return {$urandom, $urandom} & 64'hffff_ffff;
			2: return $urandom_range(0, 70000);
			default: return $urandom_range(0, 130);
		endcase
	endfunction

	// random parameter set, mostly well formed
	task automatic build_sps(output logic [7:0] bytes[$]);
		int unsigned p, cf, poc, n, nl, brk;
		byte unsigned hp[9] = '{100, 110, 122, 244, 44, 83, 86, 118, 128};
		bits_q.delete();
		p = $urandom_range(0, 1) ? hp[$urandom_range(0, 8)] : $urandom_range(0, 255);
		put(p, 8); put($urandom, 8); put($urandom, 8); put_ue($urandom_range(0, 31));
		if (is_high(p)) begin
			cf = $urandom_range(0, 9) == 0 ? $urandom_range(4, 12) : $urandom_range(0, 3);
			put_ue(cf);
			if (cf == 3) put($urandom, 1);
			put_ue($urandom_range(0, 6)); put_ue($urandom_range(0, 6)); put($urandom, 1);
			if ($urandom_range(0, 3) == 0) begin
				put(1, 1);
				nl = (cf == 3) ? 12 : 8;
				for (int i = 0; i < nl; i++) begin
					if ($urandom_range(0, 2) == 0) begin
						put(1, 1);
						n = $urandom_range(1, 70);
						for (int k = 0; k < n; k++) put_se($urandom_range(0, 40) - 20);
					end else put(0, 1);
				end
			end else put(0, 1);
		end
		put_ue($urandom_range(0, 12));
		poc = $urandom_range(0, 4);
		put_ue(poc);
		if (poc == 0) put_ue($urandom_range(0, 12));
		else if (poc == 1) begin
			put($urandom, 1); put_se($urandom_range(0, 60) - 30);
			put_se($urandom_range(0, 60) - 30);
			n = $urandom_range(0, 5) == 0 ? $urandom_range(250, 300) : $urandom_range(0, 5);
			put_ue(n);
			for (int i = 0; i < n; i++) put_se($urandom_range(0, 8) - 4);
		end
		put_ue($urandom_range(0, 16)); put($urandom, 1);
		put_ue(rnd_ue()); put_ue(rnd_ue());
		put($urandom, 1); if (bits_q[$] == 0) put($urandom, 1);
		put($urandom, 1);
		if ($urandom_range(0, 1)) begin
			put(1, 1);
			for (int i = 0; i < 4; i++) put_ue($urandom_range(0, 3) == 0 ? rnd_ue() : $urandom_range(0, 20));
		end else put(0, 1);
		// trailing vui-like junk
		put($urandom, $urandom_range(0, 24));
		brk = $urandom_range(0, 9);
		if (brk == 0) while (bits_q.size() > 8) void'(bits_q.pop_back());
		if (brk == 1) for (int i = 0; i < 40; i++) bits_q.push_back(0);
		if (brk == 2) for (int i = 0; i < 40 && bits_q.size() > 0; i++)
			bits_q[$urandom_range(0, bits_q.size() - 1)] ^= 1;
		while (bits_q.size() % 8 != 0) bits_q.push_back($urandom);
		bytes.delete();
		for (int i = 0; i < bits_q.size(); i += 8) begin
			logic [7:0] b;
			for (int k = 0; k < 8; k++) b[7-k] = bits_q[i+k];
			bytes.push_back(b);
		end
	endtask

	// ---- driver
	task automatic send_beat(logic [7:0] d, logic l);
		size_res_t r;
		while (snd_idle > 0 && $urandom_range(1, 100) <= snd_idle) begin
			valid <= 1'b0;
			@(posedge clk);
		end
		valid <= 1'b1; data_byte <= d; last_byte <= l;
		@(posedge clk);
		while (stall) @(posedge clk);
		if (predict_size(d, l, r)) sizes_q.push_back(r);
	endtask

	task automatic send_set(logic [7:0] bytes[$]);
		foreach (bytes[i]) send_beat(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic drain();
		valid <= 1'b0;
		while (sizes_q.size() != 0) @(posedge clk);
	endtask

	// ---- receiver
	always @(posedge clk) begin
		if (hold_rcv) out_stall <= 1'b1;
		else out_stall <= (rcv_idle > 0) && ($urandom_range(1, 100) <= rcv_idle);
	end

	always @(posedge clk) begin
		size_res_t e;
		cycles++;
		if (cycles > 3000000) begin
			$display("FAIL h264_sps_resolution_parser");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (sizes_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat");
			end else begin
				e = sizes_q.pop_front();
				if ({coded_width, coded_height, display_width, display_height,
					size_changed, stream_error} !== {e.cw, e.ch, e.dw, e.dh, e.chg, e.err}) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
							e.cw, e.ch, e.dw, e.dh, e.chg, e.err, coded_width, coded_height,
							display_width, display_height, size_changed, stream_error);
				end
			end
		end
	end

	// directed rows: expected typed in where obvious, else predictor only
	typedef struct {
		logic [7:0] d;
		logic       l;
		bit         known;
		size_res_t  r;
	} row_t;
	row_t rows[$];

	initial begin
		logic [7:0] bytes[$];
		int items;
		size_res_t nr;
		errors = 0; cycles = 0; snd_idle = 0; rcv_idle = 0;
		valid = 0; data_byte = 0; last_byte = 0; out_stall = 0;
		arst_n = 0;
		prv_w = 0; prv_h = 0; parse_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		nr = '{default: '0}; nr.err = 1;
		// short payloads: error with sizes zero
		rows.push_back('{8'h00, 1'b1, 1, nr});
		rows.push_back('{8'hff, 1'b1, 1, nr});
		rows.push_back('{8'h42, 1'b0, 0, nr});
		rows.push_back('{8'h00, 1'b1, 1, nr});
		// baseline 66: ue all '1' bits -> width/height 0, frames only, no crop
		rows.push_back('{8'd66, 1'b0, 0, nr});
		rows.push_back('{8'h00, 1'b0, 0, nr});
		rows.push_back('{8'h1e, 1'b0, 0, nr});
		// sps_id, log2, poc0, lsb, numref, gaps=1, w=0, h=0, fmo=1, dir=1, crop=0
		rows.push_back('{8'b11111111, 1'b0, 0, nr});
		rows.push_back('{8'b11000000, 1'b1, 1, '{16, 16, 16, 16, 1, 0}});
		// same again, no size change
		rows.push_back('{8'd66, 1'b0, 0, nr});
		rows.push_back('{8'h00, 1'b0, 0, nr});
		rows.push_back('{8'h1e, 1'b0, 0, nr});
		rows.push_back('{8'b11111111, 1'b0, 0, nr});
		rows.push_back('{8'b11000000, 1'b1, 1, '{16, 16, 16, 16, 0, 0}});
		// prefix overflow: 32 zeros in sps_id
		rows.push_back('{8'd66, 1'b0, 0, nr});
		rows.push_back('{8'h00, 1'b0, 0, nr});
		rows.push_back('{8'h1e, 1'b0, 0, nr});
		for (int i = 0; i < 4; i++) rows.push_back('{8'h00, 1'b0, 0, nr});
		rows.push_back('{8'hff, 1'b1, 1, nr});
		foreach (rows[i]) begin
			send_beat(rows[i].d, rows[i].l);
			if (rows[i].known && rows[i].r !== sizes_q[$]) begin
				errors++;
				if (errors <= 10) $display("directed row %0d disagrees with predictor", i);
			end
		end
		drain();

		items = 0;
		for (int ph = 0; ph < 3; ph++) begin
			snd_idle = ph == 0 ? 11 : (ph == 1 ? 78 : 0);
			rcv_idle = ph == 0 ? 78 : (ph == 1 ? 11 : 0);
			while (items < 580 * (ph + 1)) begin
				build_sps(bytes);
				send_set(bytes);
				items += bytes.size();
			end
			drain();
		end
		repeat (50) @(posedge clk);
		if (errors == 0 && sizes_q.size() == 0) $display("PASS h264_sps_resolution_parser");
		else $display("FAIL h264_sps_resolution_parser");
		$finish;
	end

	// long hold-off while the sender keeps offering, counted in its own process
	initial begin
		wait (cycles > 2000);
		@(posedge clk);
		hold_rcv = 1;
		repeat (400) @(posedge clk);
		hold_rcv = 0;
	end

endmodule
